>>> src/kasc_pkg.sv
// ----------------------------------------------------------------------------
// kasc_pkg: shared types and constants for the keypad angle stepper control
// Entry machine states, half-step coil table, ASCII key codes and the
// reciprocal used to turn an angle into a step count.
// ----------------------------------------------------------------------------
package kasc_pkg;

	localparam int KEY_W       = 8;
	localparam int ANGLE_W     = 10;
	localparam int STEP_W      = 14;
	localparam int COIL_W      = 4;
	localparam int PHASE_W     = 3;
	localparam int OUT_TDATA_W = 24;

	// entry machine: wait/release per key, then set rotation or discard
	typedef enum logic [3:0] {
		ST_K1_WAIT  = 4'd0,
		ST_K1_REL   = 4'd1,
		ST_K2_WAIT  = 4'd2,
		ST_K2_REL   = 4'd3,
		ST_K3_WAIT  = 4'd4,
		ST_K3_REL   = 4'd5,
		ST_K4_WAIT  = 4'd6,
		ST_K4_REL   = 4'd7,
		ST_SET      = 4'd8,
		ST_DISCARD  = 4'd9
	} entry_state_t;

	// item kind carried on tuser
	typedef enum logic {
		OP_KEYPAD = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;
	localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
	localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;
	localparam logic [KEY_W-1:0] KEY_CW    = 8'h41;
	localparam logic [KEY_W-1:0] KEY_CCW   = 8'h42;

	// steps = floor(angle * 512 / 45) = (angle * STEP_RECIP) >> STEP_SHIFT
	// (reciprocal of 45 at 2^25, exact for all 10-bit angles)
	localparam int RECIP_W    = 20;
	localparam int PROD_W     = ANGLE_W + RECIP_W;
	localparam int STEP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] STEP_RECIP = 20'd745655;
	localparam logic [STEP_W-1:0]  STEP_MAX   = 14'd11639;

	function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] pat;
		unique case (ph)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h1;
		endcase
		return pat;
	endfunction

endpackage

>>> src/keypad_angle_stepper_control_top.sv
// ----------------------------------------------------------------------------
// keypad_angle_stepper_control_top: keypad angle entry and half-step sequencer
// Each input item passes the input register and then the state/result
// registers. Throughput: one item per cycle while results are taken; the
// update from input register to state/result is a single pass (one 10x20 multiply at most).
// Reset (arst_n low, asynchronous): entry machine to first digit wait, angle,
// direction, phase, step count, run flag and coil pattern cleared.
// ----------------------------------------------------------------------------
module keypad_angle_stepper_control_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave side: one keypad sample or motor tick per transfer
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [kasc_pkg::KEY_W-1:0]           s_axis_tdata,  // [7:0] key_code
	input  logic                                 s_axis_tuser,  // [0] operation
	// master side: one result per input item
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [3:0] coil_pattern, [4] motor_running, [18:5] steps_left,
	// [22:19] entry_phase, [23] turn_ccw
	output logic [kasc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import kasc_pkg::*;

	// ---- input register -------------------------------------------------
	logic               valid_s1;
	op_t                op_s1;
	logic [KEY_W-1:0]   key_s1;
	logic               adv;

	// ---- architectural state; it doubles as the result register, since it
	//      only changes when a new result is loaded -------------------------
	entry_state_t           state_q;
	logic [ANGLE_W-1:0]     acc_q;
	logic                   ccw_q;
	logic [PHASE_W-1:0]     phase_q;
	logic [STEP_W-1:0]      step_q;
	logic                   run_q;
	logic [COIL_W-1:0]      coil_q;
	logic                   out_valid_q;

	entry_state_t           state_d;
	logic [ANGLE_W-1:0]     acc_d;
	logic                   ccw_d;
	logic [PHASE_W-1:0]     phase_d;
	logic [STEP_W-1:0]      step_d;
	logic                   run_d;
	logic [COIL_W-1:0]      coil_d;

	logic                   is_digit;
	logic                   is_dir;
	logic [ANGLE_W-1:0]     acc_next_digit;
	logic [PROD_W-1:0]      step_prod;
	logic [STEP_W-1:0]      step_load;

	// Advance the input register into the state whenever the result slot is
	// free or being drained this cycle.
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1  <= op_t'(s_axis_tuser);
			key_s1 <= s_axis_tdata;
		end
	end

	// ---- key decode and angle arithmetic -------------------------------
	assign is_digit = (key_s1 >= KEY_ZERO) && (key_s1 <= KEY_NINE);
	assign is_dir   = (key_s1 == KEY_CW) || (key_s1 == KEY_CCW);
	// acc*10 + digit, wrapped to the accumulator width
	assign acc_next_digit = (acc_q << 3) + (acc_q << 1)
		+ ANGLE_W'(key_s1 - KEY_ZERO);
	// floor(acc*512/45) through the reciprocal multiply
	assign step_prod = PROD_W'(acc_q) * PROD_W'(STEP_RECIP);
	assign step_load = step_prod[STEP_SHIFT +: STEP_W];

	// ---- next state of the entry machine -------------------------------
	always_comb begin
		state_d = state_q;
		if (op_s1 == OP_KEYPAD) begin
			unique case (state_q)
				ST_K1_WAIT: begin
					if (is_digit) state_d = ST_K1_REL;
				end
				ST_K2_WAIT, ST_K3_WAIT: begin
					if (is_digit)    state_d = entry_state_t'(state_q + 4'd1);
					else if (is_dir) state_d = ST_K4_REL;
				end
				ST_K4_WAIT: begin
					if (is_digit)    state_d = ST_DISCARD;
					else if (is_dir) state_d = ST_K4_REL;
				end
				ST_K1_REL, ST_K2_REL, ST_K3_REL: begin
					if (key_s1 == KEY_NONE) state_d = entry_state_t'(state_q + 4'd1);
				end
				ST_K4_REL: begin
					if (key_s1 == KEY_NONE) state_d = ST_SET;
				end
				ST_DISCARD: begin
					if (key_s1 == KEY_NONE) state_d = ST_K1_WAIT;
				end
				ST_SET:  state_d = ST_K1_WAIT;
				default: state_d = ST_K1_WAIT;
			endcase
		end
	end

	// ---- datapath updates: angle, direction, phase, count, coils --------
	always_comb begin
		acc_d   = acc_q;
		ccw_d   = ccw_q;
		phase_d = phase_q;
		step_d  = step_q;
		run_d   = run_q;
		coil_d  = coil_q;
		if (op_s1 == OP_TICK) begin
			// advance the phase even when idle; drive coils only while running
			phase_d = ccw_q ? (phase_q - 3'd1) : (phase_q + 3'd1);
			if (run_q) begin
				coil_d = half_step(phase_q);
				if (step_q != '0) step_d = step_q - STEP_W'(1);
				else              run_d  = 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_K1_WAIT, ST_K2_WAIT, ST_K3_WAIT: begin
					if (is_digit) acc_d = acc_next_digit;
					else if (state_q != ST_K1_WAIT && is_dir)
						ccw_d = (key_s1 == KEY_CCW);
				end
				ST_K4_WAIT: begin
					// a fourth digit drops the entry
					if (is_digit)    acc_d = '0;
					else if (is_dir) ccw_d = (key_s1 == KEY_CCW);
				end
				ST_SET: begin
					// reload and restart, even over a running rotation
					step_d = step_load;
					run_d  = 1'b1;
					acc_d  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_K1_WAIT;
			acc_q       <= '0;
			ccw_q       <= 1'b0;
			phase_q     <= '0;
			step_q      <= '0;
			run_q       <= 1'b0;
			coil_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_d;
				acc_q   <= acc_d;
				ccw_q   <= ccw_d;
				phase_q <= phase_d;
				step_q  <= step_d;
				run_q   <= run_d;
				coil_q  <= coil_d;
			end
			// hold the result until its transfer; reload on advance
			if (adv)                out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {ccw_q, state_q, step_q, run_q, coil_q};

	// ---- assertions ------------------------------------------------------
	// the motor stops only on a tick that found the count at zero
	a_stop_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> ($past(step_q) == '0))
		else $error("motor stopped with steps remaining");

	// step count never exceeds the largest loadable value
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_MAX)
		else $error("step count out of range");

	// setting the rotation clears the angle and restarts entry
	a_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == OP_KEYPAD && state_q == ST_SET)
		|=> (acc_q == '0 && state_q == ST_K1_WAIT && run_q))
		else $error("set rotation did not restart entry");

	// an empty result slot never blocks the input side
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty result slot");

endmodule
